// ----- hw/rtl/alu_ind_pkg.sv -----
// Shared types and constants for the indicator-updating ALU.
`default_nettype none

package alu_ind_pkg;

   localparam int WORD_W  = 36;
   localparam int HALF_W  = 18;
   localparam int KIND_W  = 3;
   localparam int MASK_W  = 4;

   localparam logic [WORD_W-1:0] WORD_MASK = 36'hfffffffff;
   localparam logic [WORD_W-1:0] WORD_SIGN = 36'h800000000;
   localparam logic [WORD_W-1:0] HALF_MASK = 36'o777777;
   localparam logic [WORD_W-1:0] HALF_SIGN = 36'o400000;

   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NEG   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CMP   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIMIT = 3'd4;

   localparam int UPD_CARRY = 0;
   localparam int UPD_OVF   = 1;
   localparam int UPD_ZERO  = 2;
   localparam int UPD_NEG   = 3;

   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
      logic carry;
   } ind_type;

endpackage : alu_ind_pkg

`default_nettype wire

// ----- hw/rtl/alu_indicator_update.sv -----
// Top level: 36/18-bit add, subtract, negate and compare with indicator register.
`default_nettype none

// One request enters per cycle while req_stall is low: the request is held in an input
// register, the add/subtract/compare logic and the four-bit indicator update are
// combinational behind it, and the result sits in an output register until taken.
// The indicator register feeds back only into itself, so back-to-back requests see the
// flags left by the one before. Sustained rate is one request per cycle; a stall on the
// result side backs up through the input register to req_stall.
module alu_indicator_update
   import alu_ind_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic              req_narrow,
   input  wire logic [WORD_W-1:0] req_operand_first,
   input  wire logic [WORD_W-1:0] req_operand_second,
   input  wire logic [WORD_W-1:0] req_operand_limit,
   input  wire logic [MASK_W-1:0] req_update_mask,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_value,
   output logic                   rsp_zero_flag,
   output logic                   rsp_negative_flag,
   output logic                   rsp_carry_flag,
   output logic                   rsp_overflow_flag
);

   logic              in_valid_ff;
   logic [KIND_W-1:0] kind_ff;
   logic              narrow_ff;
   logic [WORD_W-1:0] first_ff;
   logic [WORD_W-1:0] second_ff;
   logic [WORD_W-1:0] limit_ff;
   logic [MASK_W-1:0] upd_ff;

   ind_type           ind_ff;
   ind_type           ind_in;
   logic              out_valid_ff;
   logic [WORD_W-1:0] value_ff;
   logic [WORD_W-1:0] value_in;

   logic              advance;
   logic              take;

   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] sign;
   logic [WORD_W-1:0] x;
   logic [WORD_W-1:0] y;
   logic [WORD_W:0]   sum_w;
   logic [WORD_W:0]   diff_w;
   logic [WORD_W-1:0] add_r;
   logic [WORD_W-1:0] sub_r;
   logic [WORD_W-1:0] neg_r;
   logic [WORD_W-1:0] arith_r;
   logic              arith_carry;
   logic              arith_ovf;

   function automatic logic [WORD_W-1:0] req_narrow_sel(input logic sel,
                                                       input logic [WORD_W-1:0] a,
                                                       input logic [WORD_W-1:0] b);
      return sel ? a : b;
   endfunction

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign mask   = req_narrow_sel(narrow_ff, HALF_MASK, WORD_MASK);
   assign sign   = req_narrow_sel(narrow_ff, HALF_SIGN, WORD_SIGN);
   assign x      = first_ff & mask;
   assign y      = second_ff & mask;
   assign sum_w  = {1'b0, x} + {1'b0, y};
   assign diff_w = {1'b0, x} - {1'b0, y};
   assign add_r  = sum_w[WORD_W-1:0] & mask;
   assign sub_r  = diff_w[WORD_W-1:0] & mask;
   assign neg_r  = (WORD_W'(0) - x) & mask;

   always_comb begin
      ind_in      = ind_ff;
      value_in    = '0;
      arith_r     = add_r;
      arith_carry = narrow_ff ? sum_w[HALF_W] : sum_w[WORD_W];
      arith_ovf   = |(~(x ^ y) & (x ^ add_r) & sign);
      if (kind_ff == KIND_SUB) begin
         arith_r     = sub_r;
         arith_carry = diff_w[WORD_W];
         arith_ovf   = |((x ^ y) & (x ^ sub_r) & sign);
      end
      unique case (kind_ff)
         KIND_ADD, KIND_SUB: begin
            if (upd_ff[UPD_CARRY]) ind_in.carry = arith_carry;
            if (upd_ff[UPD_OVF] && arith_ovf) ind_in.ovf = 1'b1;
            if (upd_ff[UPD_ZERO]) ind_in.zero = (arith_r == '0);
            if (upd_ff[UPD_NEG]) ind_in.neg = |(arith_r & sign);
            value_in = arith_r;
         end
         KIND_NEG: begin
            if (neg_r == sign) ind_in.ovf = 1'b1;
            ind_in.neg  = |(neg_r & sign);
            ind_in.zero = (neg_r == '0);
            value_in    = neg_r;
         end
         KIND_CMP: begin
            ind_in.zero  = (first_ff == second_ff);
            ind_in.carry = (first_ff >= second_ff);
            ind_in.neg   = ($signed(first_ff) < $signed(second_ff));
         end
         KIND_LIMIT: begin
            ind_in.zero  = ((first_ff <= second_ff) && (second_ff <= limit_ff)) ||
                           ((first_ff >= second_ff) && (second_ff >= limit_ff));
            ind_in.carry = (limit_ff >= second_ff);
            ind_in.neg   = ($signed(limit_ff) < $signed(second_ff));
         end
         default: begin
            ind_in = ind_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance || !in_valid_ff) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff   <= req_kind;
         narrow_ff <= req_narrow;
         first_ff  <= req_operand_first;
         second_ff <= req_operand_second;
         limit_ff  <= req_operand_limit;
         upd_ff    <= req_update_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ind_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            ind_ff <= ind_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         value_ff <= value_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_value         = value_ff;
   assign rsp_zero_flag     = ind_ff.zero;
   assign rsp_negative_flag = ind_ff.neg;
   assign rsp_carry_flag    = ind_ff.carry;
   assign rsp_overflow_flag = ind_ff.ovf;

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ind_ff.ovf |=> ind_ff.ovf)
      else $error("overflow indicator cleared");

   a_cmp_value_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && (kind_ff == KIND_CMP || kind_ff == KIND_LIMIT))
      |=> (rsp_value == '0))
      else $error("compare request produced nonzero value");

   a_flags_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> $stable(ind_ff) && $stable(value_ff))
      else $error("result changed while stalled");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled with room available");

endmodule : alu_indicator_update

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for alu_indicator_update: directed and random requests checked against a flag predictor.
`timescale 1ns / 1ps

module testbench
   import alu_ind_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_MAX   = 10;
   localparam int RANDOM_ITEMS = 250;

   localparam logic [MASK_W-1:0] FLAGS_ALL    = '1;
   localparam logic [MASK_W-1:0] FLAGS_NONE   = '0;
   localparam logic [MASK_W-1:0] FLAGS_NO_OVF = FLAGS_ALL & ~(4'b1 << UPD_OVF);
   localparam logic [MASK_W-1:0] FLAGS_ZERO   = 4'b1 << UPD_ZERO;

   localparam logic [WORD_W-1:0] WORD_MAX_POS = WORD_SIGN ^ WORD_MASK;
   localparam logic [WORD_W-1:0] HIGH_JUNK    = 36'habcdc0000;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic              narrow;
      logic [WORD_W-1:0] first, second, limit;
      logic [MASK_W-1:0] upd;
   } alu_request_type;

   typedef struct {
      logic [WORD_W-1:0] value;
      logic              zero, neg, carry, ovf;
   } alu_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = KIND_ADD;
   logic              req_narrow = 1'b0;
   logic [WORD_W-1:0] req_operand_first = '0;
   logic [WORD_W-1:0] req_operand_second = '0;
   logic [WORD_W-1:0] req_operand_limit = '0;
   logic [MASK_W-1:0] req_update_mask = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_value;
   logic              rsp_zero_flag;
   logic              rsp_negative_flag;
   logic              rsp_carry_flag;
   logic              rsp_overflow_flag;

   ind_type        flags_model;
   alu_result_type pending_results[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;

   alu_indicator_update u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_narrow         (req_narrow),
      .req_operand_first  (req_operand_first),
      .req_operand_second (req_operand_second),
      .req_operand_limit  (req_operand_limit),
      .req_update_mask    (req_update_mask),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_zero_flag      (rsp_zero_flag),
      .rsp_negative_flag  (rsp_negative_flag),
      .rsp_carry_flag     (rsp_carry_flag),
      .rsp_overflow_flag  (rsp_overflow_flag)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   function automatic alu_result_type apply_alu_request(alu_request_type r);
      logic [WORD_W-1:0] mask, sign, x, y, res;
      logic [WORD_W:0]   wide;
      logic              carry_out, ovf_out;
      alu_result_type    out;
      mask = r.narrow ? HALF_MASK : WORD_MASK;
      sign = r.narrow ? HALF_SIGN : WORD_SIGN;
      res  = '0;
      case (r.kind)
         KIND_ADD, KIND_SUB: begin
            x = r.first & mask;
            y = r.second & mask;
            if (r.kind == KIND_ADD) begin
               wide      = {1'b0, x} + {1'b0, y};
               carry_out = wide > {1'b0, mask};
               res       = wide[WORD_W-1:0];
               ovf_out   = |(~(x ^ y) & (x ^ res) & sign);
            end else begin
               res       = x - y;
               carry_out = x < y;
               ovf_out   = |((x ^ y) & (x ^ res) & sign);
            end
            res = res & mask;
            if (r.upd[UPD_CARRY]) flags_model.carry = carry_out;
            if (r.upd[UPD_OVF] && ovf_out) flags_model.ovf = 1'b1;
            if (r.upd[UPD_ZERO]) flags_model.zero = (res == '0);
            if (r.upd[UPD_NEG]) flags_model.neg = |(res & sign);
         end
         KIND_NEG: begin
            res = (~(r.first & mask) + 1'b1) & mask;
            if (res == sign) flags_model.ovf = 1'b1;
            flags_model.neg  = |(res & sign);
            flags_model.zero = (res == '0);
         end
         KIND_CMP: begin
            flags_model.zero  = (r.first == r.second);
            flags_model.carry = (r.first >= r.second);
            flags_model.neg   = ($signed(r.first) < $signed(r.second));
         end
         KIND_LIMIT: begin
            flags_model.zero  = (r.first <= r.second && r.second <= r.limit) ||
                                (r.first >= r.second && r.second >= r.limit);
            flags_model.carry = (r.limit >= r.second);
            flags_model.neg   = ($signed(r.limit) < $signed(r.second));
         end
         default: ;
      endcase
      out.value = res;
      out.zero  = flags_model.zero;
      out.neg   = flags_model.neg;
      out.carry = flags_model.carry;
      out.ovf   = flags_model.ovf;
      return out;
   endfunction

   function automatic alu_request_type make_request(logic [KIND_W-1:0] kind, logic narrow,
                                                    logic [WORD_W-1:0] first, second, limit,
                                                    logic [MASK_W-1:0] upd);
      alu_request_type r;
      r.kind   = kind;
      r.narrow = narrow;
      r.first  = first;
      r.second = second;
      r.limit  = limit;
      r.upd    = upd;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(7))
         0: return '0;
         1: return WORD_MASK;
         2: return raw[0] ? WORD_SIGN : WORD_MAX_POS;
         3: return {raw[WORD_W-1:HALF_W],
                    raw[1] ? HALF_SIGN[HALF_W-1:0] :
                             (HALF_SIGN[HALF_W-1:0] ^ HALF_MASK[HALF_W-1:0])};
         4: return {raw[WORD_W-1:HALF_W], raw[1] ? HALF_MASK[HALF_W-1:0] : {HALF_W{1'b0}}};
         5: return {{(WORD_W-8){1'b0}}, raw[7:0]};
         default: return raw[WORD_W-1:0];
      endcase
   endfunction

   task automatic send_request(alu_request_type r);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= r.kind;
      req_narrow         <= r.narrow;
      req_operand_first  <= r.first;
      req_operand_second <= r.second;
      req_operand_limit  <= r.limit;
      req_update_mask    <= r.upd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(apply_alu_request(r));
   endtask

   function automatic void report_mismatch(string what, alu_result_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t %s: value %h/%h zero %b/%b neg %b/%b carry %b/%b ovf %b/%b "
                  , $realtime, what, want.value, rsp_value, want.zero, rsp_zero_flag,
                  want.neg, rsp_negative_flag, want.carry, rsp_carry_flag,
                  want.ovf, rsp_overflow_flag);
   endfunction

   always @(posedge clock) begin : check_results
      alu_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            want = '{default: '0};
            report_mismatch("unexpected request result", want);
         end else begin
            want = pending_results.pop_front();
            if (rsp_value !== want.value || rsp_zero_flag !== want.zero ||
                rsp_negative_flag !== want.neg || rsp_carry_flag !== want.carry ||
                rsp_overflow_flag !== want.ovf)
               report_mismatch("mismatch (expected/actual)", want);
         end
      end
   end

   task automatic test_compare();
      send_request(make_request(KIND_CMP, 1'b0, WORD_SIGN, WORD_SIGN, '0, FLAGS_ALL));
      send_request(make_request(KIND_CMP, 1'b0, WORD_SIGN, 36'd1, '0, FLAGS_NONE));
      send_request(make_request(KIND_CMP, 1'b0, '0, WORD_MASK, '0, FLAGS_ALL));
      send_request(make_request(KIND_CMP, 1'b1, HIGH_JUNK | 36'd5, 36'd5, WORD_MASK,
                                FLAGS_ALL));
   endtask

   task automatic test_limit_compare();
      send_request(make_request(KIND_LIMIT, 1'b0, 36'd10, 36'd20, 36'd30, FLAGS_ALL));
      send_request(make_request(KIND_LIMIT, 1'b1, 36'd30, 36'd20, 36'd10, FLAGS_ALL));
      send_request(make_request(KIND_LIMIT, 1'b0, 36'd10, 36'd40, 36'd30, FLAGS_NONE));
      send_request(make_request(KIND_LIMIT, 1'b0, '0, WORD_SIGN, WORD_MASK, FLAGS_ALL));
      send_request(make_request(KIND_LIMIT, 1'b0, WORD_MASK, WORD_MASK, WORD_MASK,
                                FLAGS_ALL));
   endtask

   task automatic test_add_subtract();
      send_request(make_request(KIND_ADD, 1'b0, WORD_MASK, 36'd1, '0, FLAGS_ALL));
      send_request(make_request(KIND_ADD, 1'b0, WORD_MAX_POS, 36'd1, '0, FLAGS_NONE));
      send_request(make_request(KIND_SUB, 1'b0, WORD_SIGN, 36'd1, '0, FLAGS_NO_OVF));
      send_request(make_request(KIND_SUB, 1'b0, '0, 36'd1, '0, FLAGS_ALL));
      send_request(make_request(KIND_ADD, 1'b1, HIGH_JUNK | HALF_MASK, 36'd1, '0,
                                FLAGS_ALL));
      send_request(make_request(KIND_SUB, 1'b1, HIGH_JUNK | 36'd5, 36'd5, '0, FLAGS_ALL));
      send_request(make_request(KIND_ADD, 1'b0, 36'd1, 36'd1, '0, FLAGS_ZERO));
      send_request(make_request(KIND_SUB, 1'b1, HALF_SIGN, HIGH_JUNK | 36'd1, '0,
                                FLAGS_ALL));
      send_request(make_request(KIND_ADD, 1'b0, WORD_MAX_POS, 36'd1, '0, FLAGS_ALL));
   endtask

   task automatic test_negate();
      send_request(make_request(KIND_NEG, 1'b0, '0, WORD_MASK, '0, FLAGS_NONE));
      send_request(make_request(KIND_NEG, 1'b0, 36'd1, '0, '0, FLAGS_ALL));
      send_request(make_request(KIND_NEG, 1'b1, HIGH_JUNK | HALF_SIGN, '0, '0, FLAGS_ALL));
      send_request(make_request(KIND_NEG, 1'b0, WORD_SIGN, '0, '0, FLAGS_ALL));
      send_request(make_request(KIND_NEG, 1'b1, HIGH_JUNK | HALF_MASK, '0, '0, FLAGS_ALL));
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct);
      alu_request_type r;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (RANDOM_ITEMS) begin
         r.kind   = KIND_W'($urandom_range(int'(KIND_LIMIT)));
         r.narrow = 1'($urandom_range(1));
         r.first  = random_word();
         r.second = ($urandom_range(3) == 0) ? r.first : random_word();
         r.limit  = ($urandom_range(3) == 0) ? r.second : random_word();
         r.upd    = ($urandom_range(2) == 0) ? FLAGS_ALL : MASK_W'($urandom_range(15));
         send_request(r);
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      flags_model = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_compare();
      test_limit_compare();
      test_add_subtract();
      test_negate();
      test_random_traffic(0, 0);
      test_random_traffic(74, 0);
      test_random_traffic(0, 74);
      test_random_traffic(36, 36);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/alu_ind_pkg.sv
hw/rtl/alu_indicator_update.sv
tb/testbench.sv
